@@ hw/rtl/adpi_pkg.sv @@
// Package for the ARM data-processing-immediate execute block.
// Holds the opcode and condition-code types and the flag index constants.
// No dependencies.
package adpi_pkg;

    // Data-processing opcodes, instruction bits 24:21
    typedef enum logic [3:0] {
        OP_AND = 4'h0,
        OP_EOR = 4'h1,
        OP_SUB = 4'h2,
        OP_RSB = 4'h3,
        OP_ADD = 4'h4,
        OP_ADC = 4'h5,
        OP_SBC = 4'h6,
        OP_RSC = 4'h7,
        OP_TST = 4'h8,
        OP_TEQ = 4'h9,
        OP_CMP = 4'ha,
        OP_CMN = 4'hb,
        OP_ORR = 4'hc,
        OP_MOV = 4'hd,
        OP_BIC = 4'he,
        OP_MVN = 4'hf
    } alu_op_t;

    // Condition field, instruction bits 31:28
    typedef enum logic [3:0] {
        COND_EQ = 4'h0,
        COND_NE = 4'h1,
        COND_CS = 4'h2,
        COND_CC = 4'h3,
        COND_MI = 4'h4,
        COND_PL = 4'h5,
        COND_VS = 4'h6,
        COND_VC = 4'h7,
        COND_HI = 4'h8,
        COND_LS = 4'h9,
        COND_GE = 4'ha,
        COND_LT = 4'hb,
        COND_GT = 4'hc,
        COND_LE = 4'hd,
        COND_AL = 4'he,
        COND_NV = 4'hf
    } cond_t;

    // Instruction class code expected in bits 27:25
    localparam logic [2:0] CLASS_DP_IMM = 3'b001;

    // Bit positions inside the NZCV nibble
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    // Result beat fields, kept together in the result register
    typedef struct packed {
        logic        cond_passed;
        logic        reg_written;
        logic [3:0]  dest_index;
        logic [31:0] alu_value;
        logic [3:0]  flags_nzcv;
        logic        format_error;
    } result_t;

endpackage

@@ hw/rtl/arm_data_processing_immediate.sv @@
// Top level: ARM data-processing-immediate execute stage with a 16 x 32
// register file and NZCV flags. Depends on adpi_pkg.
//
//   channel | handshake          | beat contents
//   --------+--------------------+---------------------------------------------
//   input   | in_valid/in_ready  | func, instr_word, load_index, load_value
//   output  | out_valid/out_ready| cond_passed, reg_written, dest_index,
//           |                    | alu_value, flags_nzcv, format_error
//
// One beat per clock sustained while out_ready is high; an accepted beat loads
// the input register, and its result loads the result register, raising out_valid.
// Register file and flags are written at the edge that loads the result, so
// the next beat, sitting in the input register, sees them.
// rst_n clears the register file, the flags and both valid bits at once.
// A stalled output holds both registers; in_ready stays high while either has room.
module arm_data_processing_immediate (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [31:0] instr_word,
    input  logic [3:0]  load_index,
    input  logic [31:0] load_value,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        cond_passed,
    output logic        reg_written,
    output logic [3:0]  dest_index,
    output logic [31:0] alu_value,
    output logic [3:0]  flags_nzcv,
    output logic        format_error
);

    // Input register
    logic        s1_valid_reg;
    logic        s1_func_reg;
    logic [31:0] s1_instr_reg;
    logic [3:0]  s1_lidx_reg;
    logic [31:0] s1_lval_reg;

    // Architectural state
    logic [31:0] rf_reg [16];
    logic [3:0]  flags_reg;
    logic [3:0]  flags_next;
    logic        rf_wr_en;
    logic [3:0]  rf_wr_idx;
    logic [31:0] rf_wr_data;

    // Result register
    logic                 out_valid_reg;
    adpi_pkg::result_t    res_reg;
    adpi_pkg::result_t    res_next;

    logic s1_advance;
    logic s1_fire;

    // Handshake: output slot frees when empty or being taken
    assign s1_advance = !out_valid_reg || out_ready;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_func_reg  <= func;
            s1_instr_reg <= instr_word;
            s1_lidx_reg  <= load_index;
            s1_lval_reg  <= load_value;
        end
    end

    // Execute logic
    always_comb
    begin
        logic              cc_ok;
        logic              fn, fz, fc, fv;
        logic [3:0]        rd, rn;
        logic              s_bit;
        adpi_pkg::alu_op_t op;
        adpi_pkg::cond_t   cc;
        logic [4:0]        rot;
        logic [63:0]       rot_wide;
        logic [31:0]       op2;
        logic              sc;
        logic [31:0]       a;
        logic [31:0]       add_x, add_y;
        logic              add_ci;
        logic [32:0]       sum;
        logic              logical;
        logic [31:0]       r;
        logic              c_out, v_out;
        logic              writes;

        fn    = flags_reg[adpi_pkg::FLAG_N];
        fz    = flags_reg[adpi_pkg::FLAG_Z];
        fc    = flags_reg[adpi_pkg::FLAG_C];
        fv    = flags_reg[adpi_pkg::FLAG_V];
        cc    = adpi_pkg::cond_t'(s1_instr_reg[31:28]);
        op    = adpi_pkg::alu_op_t'(s1_instr_reg[24:21]);
        s_bit = s1_instr_reg[20];
        rn    = s1_instr_reg[19:16];
        rd    = s1_instr_reg[15:12];

        // condition check
        unique case (cc)
            adpi_pkg::COND_EQ: cc_ok = fz;
            adpi_pkg::COND_NE: cc_ok = !fz;
            adpi_pkg::COND_CS: cc_ok = fc;
            adpi_pkg::COND_CC: cc_ok = !fc;
            adpi_pkg::COND_MI: cc_ok = fn;
            adpi_pkg::COND_PL: cc_ok = !fn;
            adpi_pkg::COND_VS: cc_ok = fv;
            adpi_pkg::COND_VC: cc_ok = !fv;
            adpi_pkg::COND_HI: cc_ok = fc && !fz;
            adpi_pkg::COND_LS: cc_ok = !fc || fz;
            adpi_pkg::COND_GE: cc_ok = (fn == fv);
            adpi_pkg::COND_LT: cc_ok = (fn != fv);
            adpi_pkg::COND_GT: cc_ok = !fz && (fn == fv);
            adpi_pkg::COND_LE: cc_ok = fz || (fn != fv);
            adpi_pkg::COND_AL: cc_ok = 1'b1;
            default:           cc_ok = 1'b0;
        endcase

        // immediate rotate right by twice the rotate field
        rot      = {s1_instr_reg[11:8], 1'b0};
        rot_wide = {24'd0, s1_instr_reg[7:0], 24'd0, s1_instr_reg[7:0]} >> rot;
        op2      = rot_wide[31:0];
        sc       = (rot == 5'd0) ? fc : op2[31];

        a = rf_reg[rn];

        // adder operand selection
        add_x   = a;
        add_y   = op2;
        add_ci  = 1'b0;
        logical = 1'b1;
        unique case (op) inside
            adpi_pkg::OP_SUB, adpi_pkg::OP_CMP:
            begin
                add_y   = ~op2;
                add_ci  = 1'b1;
                logical = 1'b0;
            end
            adpi_pkg::OP_RSB:
            begin
                add_x   = op2;
                add_y   = ~a;
                add_ci  = 1'b1;
                logical = 1'b0;
            end
            adpi_pkg::OP_ADD, adpi_pkg::OP_CMN:
            begin
                logical = 1'b0;
            end
            adpi_pkg::OP_ADC:
            begin
                add_ci  = fc;
                logical = 1'b0;
            end
            adpi_pkg::OP_SBC:
            begin
                add_y   = ~op2;
                add_ci  = fc;
                logical = 1'b0;
            end
            adpi_pkg::OP_RSC:
            begin
                add_x   = op2;
                add_y   = ~a;
                add_ci  = fc;
                logical = 1'b0;
            end
            default:
            begin
                logical = 1'b1;
            end
        endcase

        sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_ci};

        // result selection
        unique case (op) inside
            adpi_pkg::OP_AND, adpi_pkg::OP_TST: r = a & op2;
            adpi_pkg::OP_EOR, adpi_pkg::OP_TEQ: r = a ^ op2;
            adpi_pkg::OP_ORR:                   r = a | op2;
            adpi_pkg::OP_MOV:                   r = op2;
            adpi_pkg::OP_BIC:                   r = a & ~op2;
            adpi_pkg::OP_MVN:                   r = ~op2;
            default:                            r = sum[31:0];
        endcase

        if (logical)
        begin
            c_out = sc;
            v_out = fv;
        end
        else
        begin
            c_out = sum[32];
            v_out = ((add_x[31] ^ r[31]) & (add_y[31] ^ r[31]));
        end

        // test and compare forms leave Rd alone
        writes = !(op == adpi_pkg::OP_TST || op == adpi_pkg::OP_TEQ ||
                   op == adpi_pkg::OP_CMP || op == adpi_pkg::OP_CMN);

        // defaults: nothing changes
        flags_next            = flags_reg;
        rf_wr_en              = 1'b0;
        rf_wr_idx             = rd;
        rf_wr_data            = r;
        res_next.cond_passed  = 1'b0;
        res_next.reg_written  = 1'b0;
        res_next.dest_index   = 4'd0;
        res_next.alu_value    = 32'd0;
        res_next.format_error = 1'b0;

        if (s1_func_reg)
        begin
            // direct register load
            rf_wr_en             = 1'b1;
            rf_wr_idx            = s1_lidx_reg;
            rf_wr_data           = s1_lval_reg;
            res_next.reg_written = 1'b1;
            res_next.dest_index  = s1_lidx_reg;
            res_next.alu_value   = s1_lval_reg;
        end
        else if (s1_instr_reg[27:25] != adpi_pkg::CLASS_DP_IMM)
        begin
            res_next.format_error = 1'b1;
        end
        else
        begin
            res_next.dest_index = rd;
            if (cc_ok)
            begin
                rf_wr_en             = writes;
                res_next.cond_passed = 1'b1;
                res_next.reg_written = writes;
                res_next.alu_value   = r;
                if (s_bit)
                begin
                    flags_next = {r[31], (r == 32'd0), c_out, v_out};
                end
            end
        end
        res_next.flags_nzcv = flags_next;
    end

    // State writeback, same edge as the result load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                rf_reg[i] <= 32'd0;
            end
            flags_reg <= 4'd0;
        end
        else if (s1_fire)
        begin
            if (rf_wr_en)
            begin
                rf_reg[rf_wr_idx] <= rf_wr_data;
            end
            flags_reg <= flags_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cond_passed  = res_reg.cond_passed;
    assign reg_written  = res_reg.reg_written;
    assign dest_index   = res_reg.dest_index;
    assign alu_value    = res_reg.alu_value;
    assign flags_nzcv   = res_reg.flags_nzcv;
    assign format_error = res_reg.format_error;

endmodule
